### hw/rtl/eulerian_circuit_walker_defines.svh
// Assertion macros used by the walker engine RTL (ecw_engine).
`ifndef EULERIAN_CIRCUIT_WALKER_DEFINES_SVH
`define EULERIAN_CIRCUIT_WALKER_DEFINES_SVH
`ifndef SYNTH
`define ECW_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ECW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ECW_ASSERT(lbl, expr)
`define ECW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/ecw_pkg.sv
// ----------------------------------------------------------------------------
// ecw_pkg
// Sizes, codes and types shared by the Eulerian circuit walker.
// ----------------------------------------------------------------------------
package ecw_pkg;
  localparam int MAX_EDGES  = 1024;
  localparam int MAX_NODES  = 1024;
  localparam int NODE_AW    = 10;             // node table address
  localparam int EDGE_AW    = 10;             // edge table address
  localparam int LINK_W     = EDGE_AW + 1;    // edge index with "none"
  localparam int CNT_W      = 11;             // counts up to 1024
  localparam int STACK_DEPTH = MAX_EDGES + 1;
  localparam int STACK_AW   = 11;
  localparam int CIRC_DEPTH = 2 * MAX_EDGES;
  localparam int CIRC_AW    = 11;
  localparam int POS_W      = 12;
  localparam logic [LINK_W-1:0] EDGE_NONE = LINK_W'(MAX_EDGES);

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_REJECT = 3'd1,
    ST_SEP    = 3'd2,
    ST_NODE   = 3'd3,
    ST_END    = 3'd4
  } status_t;

  typedef enum logic {
    P_LOAD  = 1'b0,
    P_FETCH = 1'b1
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_AFIND, S_ADECIDE, S_ANEWSRC, S_ANEWDST, S_ARDHEAD, S_AWRITE,
    S_WSCAN, S_WRD, S_WEVAL, S_WEDGE, S_WPOP,
    S_FSEL, S_FRDC, S_FRDK, S_DONE
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] node_id;
  } rsp_t;
endpackage

### hw/rtl/ecw_req_if.sv
// ----------------------------------------------------------------------------
// ecw_req_if
// Request channel: add edge or fetch, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecw_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] from_node;
  logic [63:0] to_node;
  modport source (output valid, kind, from_node, to_node, input ready);
  modport sink (input valid, kind, from_node, to_node, output ready);
endinterface

### hw/rtl/ecw_rsp_if.sv
// ----------------------------------------------------------------------------
// ecw_rsp_if
// Result channel: status and node id, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecw_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] node_id;
  modport source (output valid, status, node_id, input ready);
  modport sink (input valid, status, node_id, output ready);
endinterface

### hw/rtl/ecw_ram.sv
// ----------------------------------------------------------------------------
// ecw_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ecw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/ecw_engine.sv
// ----------------------------------------------------------------------------
// ecw_engine
// Edge loading, Hierholzer walk and circuit readout over the table memories.
// ----------------------------------------------------------------------------
`include "eulerian_circuit_walker_defines.svh"

module ecw_engine (
  input  logic         clk,
  input  logic         rst,
  ecw_req_if.sink      req,
  input  logic         res_free,
  output logic         res_valid,
  output ecw_pkg::rsp_t res
);
  ecw_pkg::state_t state, state_next;
  ecw_pkg::phase_t phase;

  logic [ecw_pkg::CNT_W-1:0]   nodes_used, edges_used, comps;
  logic [ecw_pkg::POS_W-1:0]   rd_pos, circ_len;
  logic [ecw_pkg::CNT_W-1:0]   scan_idx;
  logic                        pend;
  logic [ecw_pkg::NODE_AW-1:0] pend_idx;
  logic                        hs, hd, found;
  logic [ecw_pkg::NODE_AW-1:0] si, di, start_idx, u;
  logic [63:0]                 best_key, from_q, to_q;
  logic                        kind_q;
  logic [ecw_pkg::STACK_AW-1:0] sp;
  logic [ecw_pkg::CNT_W-1:0]   rem_q;
  ecw_pkg::rsp_t               rsp_q;

  // memory ports
  logic [ecw_pkg::NODE_AW-1:0] node_ra, node_wa;
  logic                        nk_we, nhr_we;
  logic [63:0]                 nk_wd, nk_rd;
  logic [ecw_pkg::LINK_W-1:0]  nh_wd, nh_rd;
  logic [ecw_pkg::CNT_W-1:0]   nr_wd, nr_rd;
  logic                        edge_we;
  logic [ecw_pkg::EDGE_AW-1:0] edge_wa, edge_ra;
  logic [ecw_pkg::NODE_AW-1:0] et_wd, et_rd;
  logic [ecw_pkg::LINK_W-1:0]  el_wd, el_rd;
  logic                        sk_we;
  logic [ecw_pkg::STACK_AW-1:0] sk_wa, sk_ra;
  logic [ecw_pkg::NODE_AW-1:0] sk_wd, sk_rd;
  logic                        cs_we;
  logic [ecw_pkg::CIRC_AW-1:0] cs_wa, cs_ra;
  logic [ecw_pkg::NODE_AW-1:0] cs_wd, cs_rd;

  logic                        scan_issue, scan_done;
  logic [ecw_pkg::CNT_W:0]     nodes_need;
  logic [ecw_pkg::POS_W-1:0]   rd_k;
  logic                        walk_take;
  logic                        sp_room;

  ecw_ram #(.WIDTH(64), .DEPTH(ecw_pkg::MAX_NODES), .AW(ecw_pkg::NODE_AW)) u_key (
    .clk, .we(nk_we), .waddr(node_wa), .wdata(nk_wd), .raddr(node_ra), .rdata(nk_rd));
  ecw_ram #(.WIDTH(ecw_pkg::LINK_W), .DEPTH(ecw_pkg::MAX_NODES), .AW(ecw_pkg::NODE_AW))
    u_head (.clk, .we(nhr_we), .waddr(node_wa), .wdata(nh_wd), .raddr(node_ra),
            .rdata(nh_rd));
  ecw_ram #(.WIDTH(ecw_pkg::CNT_W), .DEPTH(ecw_pkg::MAX_NODES), .AW(ecw_pkg::NODE_AW))
    u_rem (.clk, .we(nhr_we), .waddr(node_wa), .wdata(nr_wd), .raddr(node_ra),
           .rdata(nr_rd));
  ecw_ram #(.WIDTH(ecw_pkg::NODE_AW), .DEPTH(ecw_pkg::MAX_EDGES), .AW(ecw_pkg::EDGE_AW))
    u_etgt (.clk, .we(edge_we), .waddr(edge_wa), .wdata(et_wd), .raddr(edge_ra),
            .rdata(et_rd));
  ecw_ram #(.WIDTH(ecw_pkg::LINK_W), .DEPTH(ecw_pkg::MAX_EDGES), .AW(ecw_pkg::EDGE_AW))
    u_elnk (.clk, .we(edge_we), .waddr(edge_wa), .wdata(el_wd), .raddr(edge_ra),
            .rdata(el_rd));
  ecw_ram #(.WIDTH(ecw_pkg::NODE_AW), .DEPTH(ecw_pkg::STACK_DEPTH), .AW(ecw_pkg::STACK_AW))
    u_stack (.clk, .we(sk_we), .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra),
             .rdata(sk_rd));
  ecw_ram #(.WIDTH(ecw_pkg::NODE_AW), .DEPTH(ecw_pkg::CIRC_DEPTH), .AW(ecw_pkg::CIRC_AW))
    u_circ (.clk, .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .raddr(cs_ra),
            .rdata(cs_rd));

  assign scan_issue = (scan_idx < nodes_used);
  assign scan_done  = !scan_issue && !pend;
  assign nodes_need = {1'b0, nodes_used} + (ecw_pkg::CNT_W+1)'(!hs)
                    + (ecw_pkg::CNT_W+1)'(!hd && (to_q != from_q));
  assign rd_k       = rd_pos - ecw_pkg::POS_W'(comps);
  assign sp_room    = (sp <= ecw_pkg::STACK_AW'(ecw_pkg::MAX_EDGES));
  assign walk_take  = (nr_rd != '0) && sp_room;
  assign req.ready  = (state == ecw_pkg::S_IDLE);
  assign res        = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    node_ra = '0; node_wa = '0; nk_we = 1'b0; nhr_we = 1'b0;
    nk_wd = '0; nh_wd = '0; nr_wd = '0;
    edge_we = 1'b0; edge_wa = '0; edge_ra = '0; et_wd = '0; el_wd = '0;
    sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;
    cs_we = 1'b0; cs_wa = '0; cs_wd = '0; cs_ra = '0;
    case (state)
      ecw_pkg::S_IDLE: begin
        if (req.valid) begin
          if (req.kind == ecw_pkg::KIND_ADD) begin
            if (phase == ecw_pkg::P_FETCH ||
                edges_used >= ecw_pkg::CNT_W'(ecw_pkg::MAX_EDGES)) begin
              state_next = ecw_pkg::S_DONE;
            end else begin
              state_next = ecw_pkg::S_AFIND;
            end
          end else if (phase == ecw_pkg::P_LOAD) begin
            state_next = ecw_pkg::S_WSCAN;
          end else begin
            state_next = ecw_pkg::S_FSEL;
          end
        end
      end
      ecw_pkg::S_AFIND: begin
        node_ra = scan_idx[ecw_pkg::NODE_AW-1:0];
        if (scan_done) state_next = ecw_pkg::S_ADECIDE;
      end
      ecw_pkg::S_ADECIDE: begin
        if (nodes_need > (ecw_pkg::CNT_W+1)'(ecw_pkg::MAX_NODES)) begin
          state_next = ecw_pkg::S_DONE;
        end else begin
          state_next = ecw_pkg::S_ANEWSRC;
        end
      end
      ecw_pkg::S_ANEWSRC: begin
        node_wa = nodes_used[ecw_pkg::NODE_AW-1:0];
        nk_wd = from_q; nh_wd = ecw_pkg::EDGE_NONE; nr_wd = '0;
        nk_we = !hs; nhr_we = !hs;
        state_next = ecw_pkg::S_ANEWDST;
      end
      ecw_pkg::S_ANEWDST: begin
        node_wa = nodes_used[ecw_pkg::NODE_AW-1:0];
        nk_wd = to_q; nh_wd = ecw_pkg::EDGE_NONE; nr_wd = '0;
        nk_we = !hd; nhr_we = !hd;
        state_next = ecw_pkg::S_ARDHEAD;
      end
      ecw_pkg::S_ARDHEAD: begin
        node_ra = si;
        state_next = ecw_pkg::S_AWRITE;
      end
      ecw_pkg::S_AWRITE: begin
        edge_we = 1'b1; edge_wa = edges_used[ecw_pkg::EDGE_AW-1:0];
        et_wd = di; el_wd = nh_rd;
        nhr_we = 1'b1; node_wa = si;
        nh_wd = edges_used; nr_wd = nr_rd + 1'b1;
        state_next = ecw_pkg::S_DONE;
      end
      ecw_pkg::S_WSCAN: begin
        node_ra = scan_idx[ecw_pkg::NODE_AW-1:0];
        if (scan_done) begin
          if (found) begin
            sk_we = 1'b1; sk_wa = '0; sk_wd = start_idx;
            state_next = ecw_pkg::S_WRD;
          end else begin
            state_next = ecw_pkg::S_FSEL;
          end
        end
      end
      ecw_pkg::S_WRD: begin
        node_ra = u;
        state_next = ecw_pkg::S_WEVAL;
      end
      ecw_pkg::S_WEVAL: begin
        if (walk_take) begin
          if (nh_rd >= ecw_pkg::EDGE_NONE) begin
            // stale head: push and retire the node
            sk_we = 1'b1; sk_wa = sp; sk_wd = u;
            nhr_we = 1'b1; node_wa = u; nh_wd = nh_rd; nr_wd = '0;
            state_next = ecw_pkg::S_WRD;
          end else begin
            edge_ra = nh_rd[ecw_pkg::EDGE_AW-1:0];
            state_next = ecw_pkg::S_WEDGE;
          end
        end else begin
          cs_we = (circ_len < ecw_pkg::POS_W'(ecw_pkg::CIRC_DEPTH));
          cs_wa = circ_len[ecw_pkg::CIRC_AW-1:0]; cs_wd = u;
          sk_ra = sp - 1'b1;
          state_next = ecw_pkg::S_WPOP;
        end
      end
      ecw_pkg::S_WEDGE: begin
        nhr_we = 1'b1; node_wa = u; nh_wd = el_rd; nr_wd = rem_q - 1'b1;
        sk_we = 1'b1; sk_wa = sp; sk_wd = u;
        state_next = ecw_pkg::S_WRD;
      end
      ecw_pkg::S_WPOP: begin
        state_next = (sp == '0) ? ecw_pkg::S_WSCAN : ecw_pkg::S_WRD;
      end
      ecw_pkg::S_FSEL: begin
        cs_ra = ecw_pkg::CIRC_AW'(circ_len - 1'b1 - rd_k);
        if (rd_pos >= ecw_pkg::POS_W'(comps) && rd_k < circ_len) begin
          state_next = ecw_pkg::S_FRDC;
        end else begin
          state_next = ecw_pkg::S_DONE;
        end
      end
      ecw_pkg::S_FRDC: begin
        node_ra = cs_rd;
        state_next = ecw_pkg::S_FRDK;
      end
      ecw_pkg::S_FRDK: begin
        state_next = ecw_pkg::S_DONE;
      end
      ecw_pkg::S_DONE: begin
        res_valid = res_free;
        if (res_free) state_next = ecw_pkg::S_IDLE;
      end
      default: begin
        state_next = ecw_pkg::S_IDLE;
      end
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ecw_pkg::P_LOAD;
      nodes_used <= '0; edges_used <= '0; comps <= '0;
      rd_pos <= '0; circ_len <= '0; pend <= 1'b0; sp <= '0;
    end else begin
      case (state)
        ecw_pkg::S_IDLE: pend <= 1'b0;
        ecw_pkg::S_AFIND, ecw_pkg::S_WSCAN: begin
          pend <= scan_issue;
          if (state == ecw_pkg::S_WSCAN && scan_done) begin
            if (found) begin
              comps <= comps + 1'b1;
              sp    <= ecw_pkg::STACK_AW'(1);
            end else begin
              phase <= ecw_pkg::P_FETCH;
            end
          end
        end
        ecw_pkg::S_ANEWSRC: if (!hs) nodes_used <= nodes_used + 1'b1;
        ecw_pkg::S_ANEWDST: if (!hd) nodes_used <= nodes_used + 1'b1;
        ecw_pkg::S_AWRITE: edges_used <= edges_used + 1'b1;
        ecw_pkg::S_WEVAL: begin
          if (walk_take) begin
            if (nh_rd >= ecw_pkg::EDGE_NONE) sp <= sp + 1'b1;
          end else begin
            if (circ_len < ecw_pkg::POS_W'(ecw_pkg::CIRC_DEPTH)) circ_len <= circ_len + 1'b1;
            sp <= sp - 1'b1;
          end
        end
        ecw_pkg::S_WEDGE: sp <= sp + 1'b1;
        ecw_pkg::S_WPOP: pend <= 1'b0;
        ecw_pkg::S_FSEL: if (rd_pos < ecw_pkg::POS_W'(comps)) rd_pos <= rd_pos + 1'b1;
        ecw_pkg::S_FRDK: rd_pos <= rd_pos + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ecw_pkg::S_IDLE: begin
        kind_q <= req.kind; from_q <= req.from_node; to_q <= req.to_node;
        scan_idx <= '0; hs <= 1'b0; hd <= 1'b0; found <= 1'b0;
        rsp_q <= '{status: ecw_pkg::ST_REJECT, node_id: '0};
      end
      ecw_pkg::S_AFIND: begin
        if (scan_issue) scan_idx <= scan_idx + 1'b1;
        pend_idx <= scan_idx[ecw_pkg::NODE_AW-1:0];
        if (pend) begin
          if (!hs && nk_rd == from_q) begin hs <= 1'b1; si <= pend_idx; end
          if (!hd && nk_rd == to_q) begin hd <= 1'b1; di <= pend_idx; end
        end
      end
      ecw_pkg::S_ANEWSRC: begin
        if (!hs) begin
          si <= nodes_used[ecw_pkg::NODE_AW-1:0];
          if (!hd && to_q == from_q) begin
            hd <= 1'b1; di <= nodes_used[ecw_pkg::NODE_AW-1:0];
          end
        end
      end
      ecw_pkg::S_ANEWDST: if (!hd) di <= nodes_used[ecw_pkg::NODE_AW-1:0];
      ecw_pkg::S_AWRITE: rsp_q <= '{status: ecw_pkg::ST_ACCEPT, node_id: '0};
      ecw_pkg::S_WSCAN: begin
        if (scan_issue) scan_idx <= scan_idx + 1'b1;
        pend_idx <= scan_idx[ecw_pkg::NODE_AW-1:0];
        if (pend && nr_rd != '0 && (!found || nk_rd < best_key)) begin
          found <= 1'b1; best_key <= nk_rd; start_idx <= pend_idx;
        end
        if (scan_done) u <= start_idx;
      end
      ecw_pkg::S_WEVAL: rem_q <= nr_rd;
      ecw_pkg::S_WEDGE: u <= et_rd;
      ecw_pkg::S_WPOP: begin
        u <= sk_rd; scan_idx <= '0; found <= 1'b0;
      end
      ecw_pkg::S_FSEL: begin
        if (rd_pos < ecw_pkg::POS_W'(comps)) begin
          rsp_q <= '{status: ecw_pkg::ST_SEP, node_id: '0};
        end else begin
          rsp_q <= '{status: ecw_pkg::ST_END, node_id: '0};
        end
      end
      ecw_pkg::S_FRDK: rsp_q <= '{status: ecw_pkg::ST_NODE, node_id: nk_rd};
      default: ;
    endcase
  end

  `ECW_ASSERT(a_sp_bound, sp <= ecw_pkg::STACK_AW'(ecw_pkg::STACK_DEPTH))
  `ECW_ASSERT(a_circ_bound, circ_len <= ecw_pkg::POS_W'(ecw_pkg::CIRC_DEPTH))
  `ECW_ASSERT(a_nodes_bound, nodes_used <= ecw_pkg::CNT_W'(ecw_pkg::MAX_NODES))
  `ECW_ASSERT_NEXT(a_frozen, phase == ecw_pkg::P_FETCH, $stable(edges_used) && $stable(nodes_used))
  `ECW_ASSERT_NEXT(a_add_kind, state == ecw_pkg::S_AWRITE, kind_q == ecw_pkg::KIND_ADD)
endmodule

### hw/rtl/eulerian_circuit_walker.sv
// Add edge: key search over the node table, one node per cycle, then node and edge writes;
// a full node table or edge table, or an add after the first fetch, is rejected.
// First fetch runs the walk: one node scan per component plus a last empty scan, and the
// walk over edges, stale heads and circuit nodes, before its result is read out.
// Later fetches return a separator, the end or a path node; one request at a time.
// Reset (rst, synchronous, active high) clears counters and phase; tables are not cleared.
// ----------------------------------------------------------------------------
// eulerian_circuit_walker
// Edge loader and Hierholzer walker with a registered result stage.
// ----------------------------------------------------------------------------
module eulerian_circuit_walker (
  input  logic      clk,
  input  logic      rst,
  ecw_req_if.sink   req,
  ecw_rsp_if.source rsp
);
  logic          res_valid, res_free, out_valid;
  ecw_pkg::rsp_t res, out_q;

  // result register is free when empty or as soon as the sink takes the held result
  assign res_free = !out_valid || rsp.ready;

  ecw_engine u_engine (
    .clk, .rst, .req, .res_free, .res_valid, .res
  );

  // hold the result until taken; the engine may start the next request meanwhile
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_q.status;
  assign rsp.node_id = out_q.node_id;
endmodule
